// File: design/heating_rate_estimator_unit_macros.svh
// Assertion macros for the heating rate estimator checker.
`ifndef HEATING_RATE_ESTIMATOR_UNIT_MACROS_SVH
`define HEATING_RATE_ESTIMATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heating rate estimator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heating rate estimator: next-cycle check failed");

`endif

// File: design/hre_pkg.sv
// Package with the shared constants and types of the heating rate estimator.
`timescale 1ns / 1ps

package hre_pkg;

  localparam int HISTORY_DEPTH = 5;
  localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam int TEMP_W     = 12;
  localparam int RISE_W     = 12;
  localparam int MINUTE_W   = 20;
  localparam int SLOPE_W    = 16;
  localparam int DIVIDEND_W = 22;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int COUNT_W    = 5;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TEMP_RISE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE_FLOOR   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE_CEILING = 2'd2;

  localparam logic [RISE_W-1:0]     RESET_MIN_RISE = 12'd16;
  localparam logic [SLOPE_W-1:0]    RESET_FLOOR    = 16'd77;
  localparam logic [SLOPE_W-1:0]    RESET_CEILING  = 16'd1024;
  localparam logic [DIVIDEND_W-1:0] RATE_SCALE     = 22'd960;
  localparam logic [SLOPE_W-1:0]    RATE_MAX       = 16'hFFFF;

  typedef struct packed {
    logic              load;
    logic              div_step;
    logic              hist_write;
    logic              scan_step;
    logic              out_load;
    logic [SLOT_W-1:0] scan_idx;
  } hre_cmd_t;

  typedef struct packed {
    logic start_record;
    logic out_free;
  } hre_status_t;

endpackage

// File: design/hre_datapath.sv
// Datapath of the heating rate estimator: edge capture, divider, history ring and scan.
`timescale 1ns / 1ps

module hre_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  hre_pkg::hre_cmd_t                       cmd,
  output hre_pkg::hre_status_t                    status,
  input  logic                                    cfg_write,
  input  logic [hre_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [hre_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [hre_pkg::TEMP_W-1:0]       temperature,
  input  logic                                    heater_on,
  input  logic [hre_pkg::MINUTE_W-1:0]            time_minute,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [hre_pkg::SLOPE_W-1:0]             slope_estimate,
  output logic                                    sample_recorded
);

  logic [hre_pkg::RISE_W-1:0]     min_temp_rise;
  logic [hre_pkg::SLOPE_W-1:0]    slope_floor;
  logic [hre_pkg::SLOPE_W-1:0]    slope_ceiling;

  logic                           heater_was_on;
  logic [hre_pkg::TEMP_W-1:0]     start_temperature;
  logic [hre_pkg::MINUTE_W-1:0]   start_minute;
  logic [hre_pkg::SLOPE_W-1:0]    history [hre_pkg::HISTORY_DEPTH];
  logic [hre_pkg::SLOT_W-1:0]     write_slot;

  logic                           recorded;
  logic [hre_pkg::DIVIDEND_W-1:0] quotient;
  logic [hre_pkg::MINUTE_W-1:0]   remainder;
  logic [hre_pkg::MINUTE_W-1:0]   divisor;
  logic [hre_pkg::SLOPE_W-1:0]    min_acc;

  logic [hre_pkg::TEMP_W:0]       rise;
  logic                           rising;
  logic                           falling;
  logic                           rise_ok;
  logic [hre_pkg::MINUTE_W-1:0]   minutes;
  logic [hre_pkg::DIVIDEND_W-1:0] dividend;
  logic [hre_pkg::MINUTE_W:0]     trial;
  logic [hre_pkg::MINUTE_W:0]     diff;
  logic                           take;
  logic [hre_pkg::SLOPE_W-1:0]    rate_sat;
  logic [hre_pkg::SLOPE_W-1:0]    hist_rd;
  logic [hre_pkg::SLOPE_W-1:0]    clipped;

  // Rise is a 13-bit signed difference; only a non-negative rise can qualify.
  assign rise     = {temperature[hre_pkg::TEMP_W-1], temperature}
                  - {start_temperature[hre_pkg::TEMP_W-1], start_temperature};
  assign rising   = heater_on & ~heater_was_on;
  assign falling  = ~heater_on & heater_was_on;
  assign rise_ok  = falling & ~rise[hre_pkg::TEMP_W]
                  & (rise[hre_pkg::RISE_W-1:0] >= min_temp_rise);
  assign minutes  = time_minute - start_minute;
  assign dividend = hre_pkg::DIVIDEND_W'(rise[hre_pkg::RISE_W-1:0]) * hre_pkg::RATE_SCALE;

  // Restoring division, one quotient bit a step. A zero divisor yields all ones.
  assign trial    = {remainder, quotient[hre_pkg::DIVIDEND_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign take     = trial >= {1'b0, divisor};
  assign rate_sat = (|quotient[hre_pkg::DIVIDEND_W-1:hre_pkg::SLOPE_W]) ?
                    hre_pkg::RATE_MAX : quotient[hre_pkg::SLOPE_W-1:0];

  assign hist_rd  = history[cmd.scan_idx];
  assign clipped  = (min_acc < slope_floor)   ? slope_floor :
                    (min_acc > slope_ceiling) ? slope_ceiling : min_acc;

  assign status.start_record = rise_ok;
  assign status.out_free     = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp_rise     <= hre_pkg::RESET_MIN_RISE;
      slope_floor       <= hre_pkg::RESET_FLOOR;
      slope_ceiling     <= hre_pkg::RESET_CEILING;
      heater_was_on     <= 1'b0;
      start_temperature <= '0;
      start_minute      <= '0;
      write_slot        <= '0;
      out_valid         <= 1'b0;
      for (int i = 0; i < hre_pkg::HISTORY_DEPTH; i++) begin
        history[i] <= hre_pkg::RESET_CEILING;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          hre_pkg::CFG_MIN_TEMP_RISE: min_temp_rise <= cfg_data[hre_pkg::RISE_W-1:0];
          hre_pkg::CFG_SLOPE_FLOOR:   slope_floor   <= cfg_data[hre_pkg::SLOPE_W-1:0];
          hre_pkg::CFG_SLOPE_CEILING: slope_ceiling <= cfg_data[hre_pkg::SLOPE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        heater_was_on <= heater_on;
        if (rising) begin
          start_temperature <= temperature;
          start_minute      <= time_minute;
        end
      end
      if (cmd.hist_write) begin
        history[write_slot] <= rate_sat;
        if (write_slot == hre_pkg::SLOT_W'(hre_pkg::HISTORY_DEPTH - 1)) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      recorded  <= rise_ok;
      quotient  <= dividend;
      remainder <= '0;
      divisor   <= minutes;
      min_acc   <= slope_ceiling;
    end
    if (cmd.div_step) begin
      quotient  <= {quotient[hre_pkg::DIVIDEND_W-2:0], take};
      remainder <= take ? diff[hre_pkg::MINUTE_W-1:0] : trial[hre_pkg::MINUTE_W-1:0];
    end
    if (cmd.scan_step && (hist_rd < min_acc)) begin
      min_acc <= hist_rd;
    end
    if (cmd.out_load) begin
      slope_estimate  <= clipped;
      sample_recorded <= recorded;
    end
  end

endmodule

// File: design/hre_controller.sv
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps

module hre_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hre_pkg::hre_status_t status,
  output hre_pkg::hre_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [hre_pkg::COUNT_W-1:0] count;
  logic [hre_pkg::COUNT_W-1:0] count_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    cmd            = '0;
    cmd.scan_idx   = count[hre_pkg::SLOT_W-1:0];
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = status.start_record ? ST_DIV : ST_SCAN;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (count == hre_pkg::COUNT_W'(hre_pkg::DIV_STEPS - 1)) begin
          count_next = '0;
          state_next = ST_WRITE;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.hist_write = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (count == hre_pkg::COUNT_W'(hre_pkg::HISTORY_DEPTH - 1)) begin
          count_next = '0;
          state_next = ST_DONE;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// File: design/heating_rate_estimator_unit.sv
// Top level of the heating rate estimator: controller plus datapath.
// A request that records a slope goes through 22 divider steps, one history write, a
// five-entry scan and one output load; any other request goes through the scan and the
// output load only. The output load waits until the output register is free. A new
// request can be taken in the cycle after the result is loaded.
// Reset (synchronous, active high) restores the register defaults and fills the history.
`timescale 1ns / 1ps

module heating_rate_estimator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hre_pkg::TEMP_W-1:0]   temperature,
  input  logic                                heater_on,
  input  logic [hre_pkg::MINUTE_W-1:0]        time_minute,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hre_pkg::SLOPE_W-1:0]         slope_estimate,
  output logic                                sample_recorded,
  input  logic                                cfg_write,
  input  logic [hre_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hre_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // The controller only accepts a request in its idle state. It then either runs
  // the bit-serial divider (when a heating run qualifies) or goes straight to the
  // minimum scan over the history ring.
  hre_pkg::hre_cmd_t    cmd;
  hre_pkg::hre_status_t status;

  hre_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the configuration registers, the heater edge state, the
  // divider, the history ring and the output register. The output register lets
  // a finished result wait while the next request is already being taken.
  hre_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .temperature     (temperature),
    .heater_on       (heater_on),
    .time_minute     (time_minute),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .slope_estimate  (slope_estimate),
    .sample_recorded (sample_recorded)
  );

endmodule

// File: design/hre_checker.sv
// Port-level checker for the heating rate estimator and its bind statement.
`timescale 1ns / 1ps
`include "heating_rate_estimator_unit_macros.svh"

module hre_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hre_pkg::SLOPE_W-1:0]     slope_estimate,
  input logic                            sample_recorded
);

  // A waiting result keeps its value until it is taken.
  `HRE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(slope_estimate) && $stable(sample_recorded))

  // Only one request is in flight: acceptance drops ready for the next cycle.
  `HRE_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // Every request needs at least the history scan, so no result appears right away.
  `HRE_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready, !$rose(out_valid))

endmodule

bind heating_rate_estimator_unit hre_checker u_hre_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .slope_estimate  (slope_estimate),
  .sample_recorded (sample_recorded)
);

// File: tb/heating_rate_estimator_unit_tb.sv
// Self-checking testbench of the heating rate estimator: directed and random heating runs.
`timescale 1ns / 1ps

module heating_rate_estimator_unit_tb;
  import hre_pkg::*;

  // A register index that maps to no register; a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

  // Cycles without any accepted request or result before the run is declared hung.
  // The limit covers the slowest correct request in the block, plus sender gaps and
  // receiver stalls that are geometric with a 0.8 chance of going on.
  localparam int STALL_LIMIT = 3000;
  localparam int MINUTE_MASK = 32'h000F_FFFF;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 160;

  typedef struct {
    logic [SLOPE_W-1:0] slope;
    logic               recorded;
  } estimate_t;

  // Tracks the estimator state on every accepted request and checks each result
  // against the oldest estimate still waiting.
  class heating_rate_predictor;
    logic [RISE_W-1:0]   min_rise;
    logic [SLOPE_W-1:0]  slope_floor;
    logic [SLOPE_W-1:0]  slope_ceiling;
    logic                heater_was_on;
    logic [TEMP_W-1:0]   start_temp;
    logic [MINUTE_W-1:0] start_min;
    logic [SLOPE_W-1:0]  history[HISTORY_DEPTH];
    int unsigned         slot;
    estimate_t           estimate_queue[$];
    int                  errors;

    function new();
      min_rise      = RESET_MIN_RISE;
      slope_floor   = RESET_FLOOR;
      slope_ceiling = RESET_CEILING;
      heater_was_on = 1'b0;
      start_temp    = '0;
      start_min     = '0;
      slot          = 0;
      errors        = 0;
      foreach (history[i]) history[i] = RESET_CEILING;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_MIN_TEMP_RISE: min_rise = value[RISE_W-1:0];
        CFG_SLOPE_FLOOR:   slope_floor = value[SLOPE_W-1:0];
        CFG_SLOPE_CEILING: slope_ceiling = value[SLOPE_W-1:0];
        default: ;
      endcase
    endfunction

    function void record_sample(logic [TEMP_W-1:0] temp, logic heat, logic [MINUTE_W-1:0] now);
      logic signed [TEMP_W:0] rise;
      logic [MINUTE_W-1:0]    minutes;
      int unsigned            quot;
      logic [SLOPE_W-1:0]     lowest;
      estimate_t              est;
      est.recorded = 1'b0;
      if (heat && !heater_was_on) begin
        start_temp = temp;
        start_min  = now;
      end
      if (!heat && heater_was_on) begin
        rise    = $signed({temp[TEMP_W-1], temp}) - $signed({start_temp[TEMP_W-1], start_temp});
        minutes = now - start_min;
        if (!rise[TEMP_W] && rise[TEMP_W-1:0] >= min_rise) begin
          if (minutes == 0) begin
            quot = RATE_MAX;
          end else begin
            quot = (int'(rise[TEMP_W-1:0]) * int'(RATE_SCALE)) / int'(minutes);
            if (quot > RATE_MAX) quot = RATE_MAX;
          end
          if (slot >= HISTORY_DEPTH) slot = 0;
          history[slot] = quot[SLOPE_W-1:0];
          slot = (slot + 1 >= HISTORY_DEPTH) ? 0 : slot + 1;
          est.recorded = 1'b1;
        end
      end
      heater_was_on = heat;
      // The scan starts at the ceiling; the floor wins over the ceiling.
      lowest = slope_ceiling;
      foreach (history[i]) if (history[i] < lowest) lowest = history[i];
      if (lowest < slope_floor) lowest = slope_floor;
      else if (lowest > slope_ceiling) lowest = slope_ceiling;
      est.slope = lowest;
      estimate_queue.push_back(est);
    endfunction

    function void check_estimate(logic [SLOPE_W-1:0] slope, logic recorded);
      estimate_t est;
      if (estimate_queue.size() == 0) begin
        $error("result with no request waiting: slope_estimate %0d", slope);
        errors++;
        return;
      end
      est = estimate_queue.pop_front();
      if (slope !== est.slope) begin
        $error("slope_estimate expected %0d actual %0d", est.slope, slope);
        errors++;
      end
      if (recorded !== est.recorded) begin
        $error("sample_recorded expected %0d actual %0d", est.recorded, recorded);
        errors++;
      end
    endfunction

    function int pending();
      return estimate_queue.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [TEMP_W-1:0]   temperature;
  logic                       heater_on;
  logic [MINUTE_W-1:0]        time_minute;
  logic                       out_valid;
  logic                       out_ready;
  logic [SLOPE_W-1:0]         slope_estimate;
  logic                       sample_recorded;
  logic                       cfg_write;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  heating_rate_predictor sb = new();

  // Idling controls: percent of cycles the sender holds back and the receiver stalls.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  // The testbench keeps its own copy of the minimum rise so random runs can aim at it.
  int cur_min_rise = RESET_MIN_RISE;
  // Running minute clock of the random stimulus.
  int clock_min;
  int items_sent = 0;
  int idle_cycles = 0;

  heating_rate_estimator_unit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .temperature     (temperature),
    .heater_on       (heater_on),
    .time_minute     (time_minute),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .slope_estimate  (slope_estimate),
    .sample_recorded (sample_recorded),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver decides at each falling edge whether it takes a result next cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Handshakes are sampled at the rising edge. A result is checked before a request
  // of the same edge is noted, since that result always belongs to an older request.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_estimate(slope_estimate, sample_recorded);
      if (in_valid && in_ready) sb.record_sample(temperature, heater_on, time_minute);
    end
  end

  // Watchdog: counts cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one request. Called at a falling edge and returns at the falling edge after
  // acceptance with valid still high, so a following request goes out back to back.
  task automatic send_sample(input int temp, input bit heat, input int minute);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    temperature <= temp[TEMP_W-1:0];
    heater_on   <= heat;
    time_minute <= minute[MINUTE_W-1:0];
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Lowers valid and waits until every result has arrived and the block has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input int value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[CFG_DATA_W-1:0];
    sb.write_register(index, value[CFG_DATA_W-1:0]);
    if (index == CFG_MIN_TEMP_RISE) cur_min_rise = value & 32'hFFF;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input int rise, input int lo_clip, input int hi_clip);
    wait_drained();
    write_register(CFG_MIN_TEMP_RISE, rise);
    write_register(CFG_SLOPE_FLOOR, lo_clip);
    write_register(CFG_SLOPE_CEILING, hi_clip);
  endtask

  // One heating run: a few idle samples, the heater switching on, a few samples while
  // it is on, and the heater switching off. Most runs rise by at least the minimum so
  // that a slope is recorded; the rest mostly fall short or cool down.
  task automatic heating_run();
    int n;
    int rise;
    int cap;
    int lo;
    int hi;
    int t0;
    int dur;
    int pick;
    int tstart;
    n = $urandom_range(0, 2);
    repeat (n) begin
      send_sample($urandom_range(0, 4095), 1'b0, clock_min);
      clock_min = (clock_min + $urandom_range(1, 30)) & MINUTE_MASK;
    end
    if ($urandom_range(99) < 80) begin
      cap = ($urandom_range(9) == 0) ? 4095 : 300;
      if (cap > 4095 - cur_min_rise) cap = 4095 - cur_min_rise;
      rise = cur_min_rise + $urandom_range(0, cap);
    end else begin
      rise = int'($urandom_range(0, cur_min_rise + 200)) - 200;
    end
    if (rise >= 0) begin
      lo = -2048;
      hi = 2047 - rise;
    end else begin
      lo = -2048 - rise;
      hi = 2047;
    end
    t0 = lo + int'($urandom_range(0, hi - lo));
    // Durations: mostly short and medium, sometimes zero, sometimes anywhere in the
    // 20-bit range, so the minute difference wraps.
    pick = $urandom_range(99);
    if (pick < 5) dur = 0;
    else if (pick < 40) dur = $urandom_range(1, 64);
    else if (pick < 85) dur = $urandom_range(65, 4000);
    else dur = $urandom_range(0, MINUTE_MASK);
    tstart = clock_min;
    send_sample(t0, 1'b1, tstart);
    n = $urandom_range(0, 3);
    repeat (n) begin
      send_sample($urandom_range(0, 4095), 1'b1,
                  (tstart + int'($urandom_range(0, dur))) & MINUTE_MASK);
    end
    send_sample(t0 + rise, 1'b0, (tstart + dur) & MINUTE_MASK);
    clock_min = (tstart + dur + int'($urandom_range(0, 50))) & MINUTE_MASK;
  endtask

  initial begin
    int phase;
    int start_count;
    rst         = 1'b1;
    in_valid    = 1'b0;
    temperature = '0;
    heater_on   = 1'b0;
    time_minute = '0;
    out_ready   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    clock_min   = $urandom_range(0, MINUTE_MASK);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset settings: minimum rise 16, floor 77, ceiling 1024.
    // Heater off from the start: nothing recorded, estimate is the ceiling.
    send_sample(0, 1'b0, 0);
    // Full-scale rise across the minute wrap (32 minutes): the rate saturates.
    send_sample(-2048, 1'b1, 20'hFFFF0);
    send_sample(2047, 1'b0, 20'h00010);
    // Zero duration records the saturated rate.
    send_sample(100, 1'b1, 50);
    send_sample(116, 1'b0, 50);
    // A cooling run has a negative rise and records nothing.
    send_sample(500, 1'b1, 100);
    send_sample(400, 1'b0, 200);
    // A rise one short of the minimum records nothing.
    send_sample(0, 1'b1, 1000);
    send_sample(15, 1'b0, 1010);
    // A run with a sample in the middle: 16 over 60 minutes gives 256.
    send_sample(0, 1'b1, 0);
    send_sample(30, 1'b1, 5);
    send_sample(16, 1'b0, 60);
    // A slow run gives 15, which the floor lifts to 77.
    send_sample(0, 1'b1, 2000);
    send_sample(16, 1'b0, 3000);

    // Floor above ceiling and a zero minimum rise: the floor must win, and a flat run
    // records either the saturated rate (zero minutes) or zero.
    apply_settings(0, 2000, 500);
    send_sample(5, 1'b1, 7);
    send_sample(5, 1'b0, 7);
    send_sample(5, 1'b1, 7);
    send_sample(5, 1'b0, 9);

    // A write to an unmapped index must leave every register alone.
    wait_drained();
    write_register(CFG_UNMAPPED, 32'hFFFF);
    send_sample(2047, 1'b0, MINUTE_MASK);

    // Widest settings: only the largest possible rise counts, nothing is clipped.
    apply_settings(4095, 0, 65535);
    send_sample(-1, 1'b0, 0);
    send_sample(-2048, 1'b1, MINUTE_MASK);
    send_sample(2047, 1'b0, 999);
    send_sample(0, 1'b1, 5);
    send_sample(2047, 1'b0, 10);

    // Random part. Each phase picks settings and an idling pattern; the pattern cycles
    // through no idling, a slow sender, a slow receiver, and both slow.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(16, 77, 1024);
        1: apply_settings(0, 0, 65535);
        2: apply_settings(4095, 65535, 0);
        3: apply_settings(1, 0, 0);
        default: apply_settings($urandom_range(0, 64), $urandom_range(0, 600),
                                $urandom_range(200, 4000));
      endcase
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 80;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 80;
        end
        default: begin
          sender_idle_pct = 36;
          receiver_stall_pct = 36;
        end
      endcase
      start_count = items_sent;
      while (items_sent - start_count < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          heating_run();
        end else begin
          // Noise: any value of every field, heater edges at random.
          send_sample($urandom_range(0, 4095), $urandom_range(0, 1),
                      $urandom_range(0, MINUTE_MASK));
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
